### src/iddt_pkg.sv
// Shared types and constants for the indentation token scanner.
// No dependencies.
package iddt_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int CNT_W           = 8;
  localparam int COL_W           = 16;
  localparam int TABW_W          = 4;
  localparam logic [TABW_W-1:0] TAB_WIDTH_RESET = 4'd4;

  typedef enum logic [1:0] {
    KIND_INDENT  = 2'd0,
    KIND_DEDENT  = 2'd1,
    KIND_NEWLINE = 2'd2
  } tok_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WALK,
    S_EMIT
  } scan_state_t;

  typedef struct packed {
    logic        valid_indent;
    logic        valid_dedent;
    logic        valid_newline;
    logic        at_end;
    logic        newline_seen;
    logic [11:0] space_count;
    logic [9:0]  tab_count;
    logic        blank_or_comment;
    logic        end_after_space;
  } scan_req_t;

  typedef struct packed {
    logic      found;
    tok_kind_t token_kind;
  } scan_res_t;

endpackage

### src/iddt_stack.sv
// Indentation column stack storage: one write port, one registered read port.
// Depends on iddt_pkg.
module iddt_stack import iddt_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int ADDR_W = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [COL_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [COL_W-1:0]  rdata
);

  logic [COL_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/iddt_seq.sv
// Scan sequencer: decision logic, stack walk with one shared compare, level state.
// Depends on iddt_pkg and iddt_stack.
module iddt_seq import iddt_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  scan_req_t         req,
  input  logic [TABW_W-1:0] tab_width,
  output logic              res_valid,
  input  logic              res_taken,
  output scan_res_t         res
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(STACK_DEPTH);

  scan_state_t       state, state_next;
  scan_req_t         item;
  logic [COL_W-1:0]  col;
  logic [CNT_W-1:0]  level_count;
  logic [CNT_W-1:0]  dedents_owed;
  logic [ADDR_W-1:0] walk_idx;
  logic [CNT_W-1:0]  walk_n;

  logic              accept;
  logic              multi;
  logic [CNT_W-1:0]  rd_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  rd_data;
  logic              ent_zero;
  logic [COL_W-1:0]  ent;
  logic              ent_gt, ent_lt;
  logic              walk_more;

  logic              do_push, do_pop, do_owe_dec, do_walk, do_done;
  scan_res_t         res_d;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign multi     = (level_count > CNT_W'(1));

  always_comb begin
    unique case (state)
      S_CMP:   rd_sel = level_count - CNT_W'(2);
      S_WALK:  rd_sel = CNT_W'(walk_idx) - CNT_W'(1);
      default: rd_sel = level_count - CNT_W'(1);
    endcase
  end
  assign rd_addr = rd_sel[ADDR_W-1:0];

  iddt_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (do_push),
    .waddr (level_count[ADDR_W-1:0]),
    .wdata (col),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // shared compare: top entry in S_CMP, walked entry in S_WALK; entry 0 is always 0
  assign ent_zero  = (state == S_WALK) ? (walk_idx == '0) : (level_count == CNT_W'(1));
  assign ent       = ent_zero ? '0 : rd_data;
  assign ent_gt    = (col > ent);
  assign ent_lt    = (col < ent);
  assign walk_more = ent_lt;

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_owe_dec = 1'b0;
    do_walk    = 1'b0;
    do_done    = 1'b0;
    res_d      = '{found: 1'b0, token_kind: KIND_INDENT};
    unique case (state)
      S_CMP: begin
        do_done = 1'b1;
        if (item.valid_indent && item.valid_dedent && item.valid_newline) begin
          res_d = '{found: 1'b0, token_kind: KIND_INDENT};
        end else if (dedents_owed != '0 && item.valid_dedent) begin
          do_owe_dec = 1'b1;
          do_pop     = 1'b1;
          res_d      = '{found: 1'b1, token_kind: KIND_DEDENT};
        end else if (item.at_end) begin
          if (multi && item.valid_dedent) begin
            do_pop = 1'b1;
            res_d  = '{found: 1'b1, token_kind: KIND_DEDENT};
          end
        end else if (!item.newline_seen) begin
          res_d = '{found: 1'b0, token_kind: KIND_INDENT};
        end else if (item.blank_or_comment) begin
          if (item.valid_newline) begin
            res_d = '{found: 1'b1, token_kind: KIND_NEWLINE};
          end
        end else if (item.end_after_space) begin
          if (multi && item.valid_dedent) begin
            do_pop = 1'b1;
            res_d  = '{found: 1'b1, token_kind: KIND_DEDENT};
          end else if (item.valid_newline) begin
            res_d = '{found: 1'b1, token_kind: KIND_NEWLINE};
          end
        end else if (ent_gt && item.valid_indent) begin
          do_push = (level_count < MAX_CNT);
          res_d   = '{found: 1'b1, token_kind: KIND_INDENT};
        end else if (ent_lt && item.valid_dedent) begin
          do_done = 1'b0;
          do_walk = 1'b1;
        end else if (item.valid_newline) begin
          res_d = '{found: 1'b1, token_kind: KIND_NEWLINE};
        end
      end
      S_WALK: begin
        if (!walk_more) begin
          do_done = 1'b1;
          do_pop  = 1'b1;
          res_d   = '{found: 1'b1, token_kind: KIND_DEDENT};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_CMP;
      S_CMP:  state_next = do_walk ? S_WALK : S_EMIT;
      S_WALK: if (do_done) state_next = S_EMIT;
      S_EMIT: if (res_taken) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      level_count  <= CNT_W'(1);
      dedents_owed <= '0;
    end else begin
      state <= state_next;
      if (do_push) begin
        level_count <= level_count + CNT_W'(1);
      end else if (do_pop && multi) begin
        level_count <= level_count - CNT_W'(1);
      end
      if (do_owe_dec) begin
        dedents_owed <= dedents_owed - CNT_W'(1);
      end else if (state == S_WALK && do_done) begin
        dedents_owed <= walk_n - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
      col  <= COL_W'(req.space_count) + COL_W'(req.tab_count) * COL_W'(tab_width);
    end
    if (do_walk) begin
      walk_idx <= rd_addr;
      walk_n   <= CNT_W'(1);
    end else if (state == S_WALK && walk_more) begin
      walk_idx <= walk_idx - ADDR_W'(1);
      walk_n   <= walk_n + CNT_W'(1);
    end
    if (do_done) begin
      res <= res_d;
    end
  end

  assign res_valid = (state == S_EMIT);

endmodule

### src/indent_dedent_token_scanner.sv
// An input transfer passes the compare state, a stack walk when a dedent reaches
// below the top entry, then the emit state and the output register.
// A new request is taken only once the last result has been handed on; the walk reads the
// stack through a single registered port, one entry per cycle.
// Reset (rst, synchronous): one level at column 0, no dedents owed, tab width 4.
// Top level: tab width register, sequencer, output register. Depends on iddt_pkg and iddt_seq.
module indent_dedent_token_scanner import iddt_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [TABW_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  scan_req_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output scan_res_t         out_data
);

  logic [TABW_W-1:0] tab_width;
  logic              res_valid;
  logic              res_taken;
  scan_res_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= TAB_WIDTH_RESET;
    end else if (cfg_write) begin
      tab_width <= cfg_data;
    end
  end

  iddt_seq #(.STACK_DEPTH(STACK_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req       (in_data),
    .tab_width (tab_width),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res)
  );

  assign res_taken = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_data <= res;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for indent_dedent_token_scanner: directed and random scan requests,
// predicted tokens checked per transfer, tab width swept across phases with varied idling.
// Depends on iddt_pkg and the scanner RTL.
module tb;
  import iddt_pkg::*;

  localparam int GEN = 0;
  localparam int CHK = 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_SPACES = 4095;
  localparam scan_res_t NO_TOKEN = '{found: 1'b0, token_kind: KIND_INDENT};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic [TABW_W-1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  scan_req_t in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  scan_res_t out_data;

  indent_dedent_token_scanner u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // two copies of the scanner state: one steers generation, one checks transfers
  logic [COL_W-1:0]  lvl [2][STACK_DEPTH_DEF];
  int unsigned       depth [2];
  logic [CNT_W-1:0]  owed [2];
  logic [TABW_W-1:0] tabw [2];

  scan_req_t   pending [$];
  scan_res_t   tokens_due [$];
  int unsigned reqs_queued = 0;
  int unsigned reqs_taken = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned peak_depth = 1;
  int unsigned declined = 0;
  int unsigned kind_seen [3] = '{0, 0, 0};
  bit          req_took = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  function automatic scan_res_t token(input tok_kind_t k);
    scan_res_t t;
    t.found = 1'b1;
    t.token_kind = k;
    return t;
  endfunction

  function automatic void level_pop(input int w);
    if (depth[w] > 1) depth[w]--;
  endfunction

  function automatic scan_res_t scan_predict(input int w, input scan_req_t r);
    int unsigned col, top, n;
    col = (32'(r.space_count) + 32'(r.tab_count) * 32'(tabw[w])) & 32'hFFFF;
    top = lvl[w][depth[w]-1];
    n = 0;
    if (r.valid_indent && r.valid_dedent && r.valid_newline) return NO_TOKEN;
    if (owed[w] != 0 && r.valid_dedent) begin
      owed[w]--;
      level_pop(w);
      return token(KIND_DEDENT);
    end
    if (r.at_end) begin
      if (depth[w] > 1 && r.valid_dedent) begin
        level_pop(w);
        return token(KIND_DEDENT);
      end
      return NO_TOKEN;
    end
    if (!r.newline_seen) return NO_TOKEN;
    if (r.blank_or_comment) return r.valid_newline ? token(KIND_NEWLINE) : NO_TOKEN;
    if (r.end_after_space) begin
      if (depth[w] > 1 && r.valid_dedent) begin
        level_pop(w);
        return token(KIND_DEDENT);
      end
      return r.valid_newline ? token(KIND_NEWLINE) : NO_TOKEN;
    end
    if (col > top && r.valid_indent) begin
      // full stack: INDENT still goes out, the level is dropped
      if (depth[w] < STACK_DEPTH_DEF) begin
        lvl[w][depth[w]] = col[COL_W-1:0];
        depth[w]++;
      end
      return token(KIND_INDENT);
    end
    if (col < top && r.valid_dedent) begin
      for (int i = int'(depth[w]) - 1; i >= 0 && lvl[w][i] > col; i--) n++;
      if (n > 0) begin
        owed[w] = CNT_W'(n - 1);
        level_pop(w);
        return token(KIND_DEDENT);
      end
    end
    return r.valid_newline ? token(KIND_NEWLINE) : NO_TOKEN;
  endfunction

  // {indent, dedent, newline} acceptance; all three set only now and then
  function automatic logic [2:0] pick_flags();
    logic [2:0] f;
    f = {$urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85};
    if (f == 3'b111 && $urandom_range(0, 9) != 0) f[$urandom_range(0, 2)] = 1'b0;
    return f;
  endfunction

  // well-formed line at a given column, split randomly between tabs and spaces
  function automatic scan_req_t make_line(input logic [2:0] f, input int unsigned col);
    scan_req_t r;
    int unsigned c, tabs, most;
    c = (col > MAX_SPACES) ? MAX_SPACES : col;
    most = c / tabw[GEN];
    tabs = $urandom_range(0, (most > 1023) ? 1023 : most);
    r = '0;
    {r.valid_indent, r.valid_dedent, r.valid_newline} = f;
    r.newline_seen = 1'b1;
    r.tab_count = 10'(tabs);
    r.space_count = 12'(c - tabs * tabw[GEN]);
    return r;
  endfunction

  task automatic queue_req(input scan_req_t r);
    void'(scan_predict(GEN, r));
    pending.push_back(r);
    reqs_queued++;
  endtask

  task automatic settle_owed();
    logic [2:0] f;
    while (owed[GEN] != 0) begin
      f = pick_flags();
      f[1] = 1'b1;
      queue_req(make_line(f, $urandom_range(0, MAX_SPACES)));
    end
  endtask

  task automatic unwind(input logic [2:0] f, input int unsigned col);
    settle_owed();
    queue_req(make_line(f, col));
    settle_owed();
  endtask

  // fill the stack to the top, push past it, then fall back to column 0 in one walk
  task automatic climb_full();
    unwind(3'b010, 0);
    repeat (STACK_DEPTH_DEF + 3)
      queue_req(make_line({2'b10, 1'($urandom_range(0, 1))},
                          lvl[GEN][depth[GEN]-1] + $urandom_range(1, 20)));
    unwind(3'b010, 0);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (reqs_taken != reqs_queued || tokens_due.size() != 0);
  endtask

  task automatic random_phase(input int unsigned tw, input int unsigned items,
                              input int unsigned gap, input int unsigned stall,
                              input bit climb, input bit hold);
    int unsigned stop, top, pick, sel, col, i;
    logic [2:0]  f;
    logic [31:0] bits;
    scan_req_t   r;
    wait_drained();
    cfg_data <= TABW_W'(tw);
    cfg_write <= 1'b1;
    tabw[GEN] = TABW_W'(tw);
    tabw[CHK] = TABW_W'(tw);
    @(negedge clk) cfg_write <= 1'b0;
    @(posedge clk);
    send_gap_pct = gap;
    stall_pct = stall;
    if (hold) holds_asked++;
    stop = reqs_queued + items;
    if (climb) climb_full();
    while (reqs_queued < stop) begin
      pick = $urandom_range(0, 99);
      top = lvl[GEN][depth[GEN]-1];
      f = pick_flags();
      if (pick < 60) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) col = top + $urandom_range(1, 40);
        else if (sel < 6 || depth[GEN] == 1) col = top;
        else begin
          i = $urandom_range(0, depth[GEN] - 2);
          col = $urandom_range(lvl[GEN][i], lvl[GEN][i+1] - 1);
        end
        queue_req(make_line(f, col));
      end else if (pick < 72) begin
        r = make_line(f, $urandom_range(0, MAX_SPACES));
        case ($urandom_range(0, 3))
          0: r.at_end = 1'b1;
          1: r.newline_seen = 1'b0;
          2: r.blank_or_comment = 1'b1;
          default: r.end_after_space = 1'b1;
        endcase
        queue_req(r);
      end else if (pick < 80) begin
        bits = $urandom;
        queue_req(bits[$bits(scan_req_t)-1:0]);
      end else if (pick < 90) begin
        if (depth[GEN] > 1) begin
          i = $urandom_range(0, depth[GEN] - 2);
          f[1] = 1'b1;
          unwind(f, $urandom_range(lvl[GEN][i], lvl[GEN][i+1] - 1));
        end
      end else begin
        repeat ($urandom_range(3, 8))
          queue_req(make_line({2'b10, f[0]}, lvl[GEN][depth[GEN]-1] + $urandom_range(1, 40)));
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_took) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data <= pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, including the long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: check output transfers, predict on input transfers, watchdog
  always @(posedge clk) begin
    scan_res_t want;
    if (rst) begin
      req_took = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (!out_data.found) declined++;
        else if (out_data.token_kind <= KIND_NEWLINE) kind_seen[out_data.token_kind]++;
        if (tokens_due.size() == 0) begin
          $display("%0t: token with none expected: found %0b kind %0d", $time,
                   out_data.found, out_data.token_kind);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          if (out_data.found !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, out_data.found);
            errors++;
          end
          if (out_data.token_kind !== want.token_kind) begin
            $display("%0t: token kind expected %0d got %0d", $time, want.token_kind,
                     out_data.token_kind);
            errors++;
          end
        end
      end
      req_took = in_valid && !in_stall;
      if (req_took) begin
        tokens_due.push_back(scan_predict(CHK, in_data));
        reqs_taken++;
        if (depth[CHK] > peak_depth) peak_depth = depth[CHK];
      end
      if (req_took || (out_valid && !out_stall) || cfg_write) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    scan_req_t   r;
    int unsigned tw_last;
    for (int w = 0; w < 2; w++) begin
      for (int i = 0; i < STACK_DEPTH_DEF; i++) lvl[w][i] = '0;
      depth[w] = 1;
      owed[w] = '0;
      tabw[w] = TAB_WIDTH_RESET;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines at the reset tab width
    queue_req(make_line(3'b111, 4));
    r = make_line(3'b010, 0); r.at_end = 1'b1; queue_req(r);
    r = make_line(3'b001, 8); r.newline_seen = 1'b0; queue_req(r);
    r = make_line(3'b001, 8); r.blank_or_comment = 1'b1; queue_req(r);
    r = make_line(3'b110, 8); r.blank_or_comment = 1'b1; queue_req(r);
    r = make_line(3'b011, 0); r.end_after_space = 1'b1; queue_req(r);
    r = make_line(3'b110, 0); r.end_after_space = 1'b1; queue_req(r);
    queue_req(make_line(3'b100, 4));
    queue_req(make_line(3'b101, 8));
    queue_req(make_line(3'b100, 12));
    queue_req(make_line(3'b001, 12));
    queue_req(make_line(3'b110, 12));
    queue_req(make_line(3'b011, 20));
    r = make_line(3'b011, 0); r.end_after_space = 1'b1; queue_req(r);
    r = '0;
    r.valid_indent = 1'b1;
    r.newline_seen = 1'b1;
    r.space_count = '1;
    r.tab_count = '1;
    queue_req(r);
    queue_req(make_line(3'b010, 0));
    r = make_line(3'b010, 0); r.at_end = 1'b1; queue_req(r);
    queue_req(make_line(3'b001, 0));
    queue_req(make_line(3'b111, 0));
    queue_req(make_line(3'b010, 30));
    r = make_line(3'b010, 0); r.at_end = 1'b1; queue_req(r);
    queue_req(make_line(3'b100, 6));
    queue_req(make_line(3'b001, 2));
    queue_req(make_line(3'b000, 3));
    r = make_line(3'b010, 0); r.at_end = 1'b1; queue_req(r);

    tw_last = $urandom_range(1, 8);
    random_phase(1, 250, 0, 0, 1'b1, 1'b0);
    random_phase(8, 200, 48, 0, 1'b0, 1'b0);
    random_phase(3, 250, 0, 48, 1'b1, 1'b1);
    random_phase(tw_last, 230, 7, 7, 1'b0, 1'b0);

    wait_drained();
    repeat (150) @(posedge clk);
    $display("covered %0d requests at tab widths 4, 1, 8, 3 and %0d; deepest stack %0d of %0d",
             reqs_taken, tw_last, peak_depth, STACK_DEPTH_DEF);
    $display("tokens: %0d INDENT, %0d DEDENT, %0d NEWLINE, %0d declined",
             kind_seen[KIND_INDENT], kind_seen[KIND_DEDENT], kind_seen[KIND_NEWLINE], declined);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
